>>> hw/rtl/beep_pattern_sequencer_assert.svh
// assertion macros used by the assertion checker in hw/rtl/bps_checker.sv
`ifndef BEEP_PATTERN_SEQUENCER_ASSERT_SVH
`define BEEP_PATTERN_SEQUENCER_ASSERT_SVH

// clocked check, switched off while reset is asserted
`define BPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked implication check, switched off while reset is asserted
`define BPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bps_pkg.sv
package bps_pkg;

  // default widths of the internal counters
  localparam int unsigned TIME_BITS_DEF  = 16;
  localparam int unsigned COUNT_BITS_DEF = 8;

  // fixed field widths of the channel words
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned REPS_W  = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned BEEPS_W = 8;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FORCE_ON  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FORCE_OFF = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TOGGLE    = 3'd4;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ON   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT = 2'd2;

  // largest reportable beep count
  localparam logic [BEEPS_W-1:0] BEEPS_MAX = '1;

  // one input word as held in the input register
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REPS_W-1:0] repetitions;
    logic [TIME_W-1:0] on_time_ms;
    logic [TIME_W-1:0] off_time_ms;
  } bps_item_t;

endpackage

>>> hw/rtl/bps_if.sv
// input channel: commands and millisecond ticks
interface bps_in_if import bps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [REPS_W-1:0] repetitions;
  logic [TIME_W-1:0] on_time_ms;
  logic [TIME_W-1:0] off_time_ms;

  modport source (output valid, kind, repetitions, on_time_ms, off_time_ms, input ready);
  modport sink   (input valid, kind, repetitions, on_time_ms, off_time_ms, output ready);
endinterface

// output channel: buzzer status after each word
interface bps_out_if import bps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               buzzer_level;
  logic [PHASE_W-1:0] phase;
  logic [BEEPS_W-1:0] beeps_left;
  logic               sequence_done;

  modport source (output valid, buzzer_level, phase, beeps_left, sequence_done, input ready);
  modport sink   (input valid, buzzer_level, phase, beeps_left, sequence_done, output ready);
endinterface

>>> hw/rtl/bps_core.sv
module bps_core import bps_pkg::*; #(
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  bps_item_t        item_i,
  output logic             item_ready_o,
  bps_out_if.source        out_o
);

  localparam int unsigned EL_W = TIME_BITS + 1;

  // pattern state
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [EL_W-1:0]       elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0]  on_dur_q, on_dur_d;
  logic [TIME_BITS-1:0]  off_dur_q, off_dur_d;
  logic                  in_seq_q, in_seq_d;
  logic                  drive_q, drive_d;
  logic                  done_d;

  // result register
  logic                  out_vld_q;
  logic                  res_level_q;
  logic [PHASE_W-1:0]    res_phase_q;
  logic [BEEPS_W-1:0]    res_beeps_q;
  logic                  res_done_q;

  logic                  fire;
  logic [EL_W-1:0]       el_inc;
  logic [COUNT_BITS-1:0] rem_dec;
  logic [COUNT_BITS-1:0] reps_m;
  logic [BEEPS_W-1:0]    beeps_d;

  assign item_ready_o = !out_vld_q || out_o.ready;
  assign fire         = item_valid_i && item_ready_o;

  // saturating elapsed count, clamped beep count, masked repetitions
  assign el_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + EL_W'(1);
  assign rem_dec = (rem_q != '0) ? rem_q - COUNT_BITS'(1) : rem_q;
  assign reps_m  = COUNT_BITS'(item_i.repetitions);

  // next state for one word
  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    elapsed_d = elapsed_q;
    on_dur_d  = on_dur_q;
    off_dur_d = off_dur_q;
    in_seq_d  = in_seq_q;
    drive_d   = drive_q;
    done_d    = 1'b0;
    case (item_i.kind)
      KIND_TICK: begin
        elapsed_d = el_inc;
        if (phase_q == PH_ON) begin
          if (in_seq_q && (el_inc > {1'b0, on_dur_q})) begin
            drive_d   = 1'b0;
            elapsed_d = '0;
            rem_d     = rem_dec;
            if (rem_dec != '0) begin
              phase_d = PH_WAIT;
            end else begin
              phase_d  = PH_IDLE;
              in_seq_d = 1'b0;
              done_d   = 1'b1;
            end
          end
        end else if (phase_q == PH_WAIT) begin
          if (el_inc >= {1'b0, off_dur_q}) begin
            drive_d   = 1'b1;
            elapsed_d = '0;
            phase_d   = PH_ON;
          end
        end
      end
      KIND_START: begin
        rem_d     = (reps_m == '0) ? COUNT_BITS'(1) : reps_m;
        on_dur_d  = TIME_BITS'(item_i.on_time_ms);
        off_dur_d = TIME_BITS'(item_i.off_time_ms);
        elapsed_d = '0;
        drive_d   = 1'b1;
        phase_d   = PH_ON;
        in_seq_d  = 1'b1;
      end
      KIND_FORCE_ON: begin
        rem_d    = '0;
        drive_d  = 1'b1;
        in_seq_d = 1'b0;
        phase_d  = PH_ON;
      end
      KIND_FORCE_OFF: begin
        rem_d    = '0;
        drive_d  = 1'b0;
        in_seq_d = 1'b0;
        phase_d  = PH_IDLE;
      end
      KIND_TOGGLE: begin
        rem_d    = '0;
        in_seq_d = 1'b0;
        drive_d  = !drive_q;
        phase_d  = drive_q ? PH_IDLE : PH_ON;
      end
      default: begin
      end
    endcase
  end

  // beep count as reported, clamped to the output width
  assign beeps_d = (rem_d > COUNT_BITS'(BEEPS_MAX)) ? BEEPS_MAX : BEEPS_W'(rem_d);

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      rem_q     <= '0;
      elapsed_q <= '0;
      on_dur_q  <= '0;
      off_dur_q <= '0;
      in_seq_q  <= 1'b0;
      drive_q   <= 1'b0;
    end else if (fire) begin
      phase_q   <= phase_d;
      rem_q     <= rem_d;
      elapsed_q <= elapsed_d;
      on_dur_q  <= on_dur_d;
      off_dur_q <= off_dur_d;
      in_seq_q  <= in_seq_d;
      drive_q   <= drive_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_level_q <= drive_d;
      res_phase_q <= phase_d;
      res_beeps_q <= beeps_d;
      res_done_q  <= done_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.buzzer_level  = res_level_q;
  assign out_o.phase         = res_phase_q;
  assign out_o.beeps_left    = res_beeps_q;
  assign out_o.sequence_done = res_done_q;

endmodule

>>> hw/rtl/beep_pattern_sequencer.sv
// Buzzer beep pattern sequencer.
// Input channel in_i takes one word per cycle while its ready is high: a millisecond tick, a start
// command (repetitions, on time, off time), force on, force off or toggle.
// Output channel out_o returns exactly one word per input word, giving the
// buzzer level, phase, beeps still to sound and a flag set when a tick
// ended a sequence on its own.
// An accepted word passes through the input register, then through the state
// update into the result register.
// The block takes one word per cycle while the receiver keeps up; the state update is a
// compare and increment on the elapsed counter, so nothing in the path iterates.
// When the receiver stalls, the result register holds its word and the
// input register holds the next one; ready on in_i drops only once both are
// full, and no word is lost or repeated.
// Reset (rst_ni low, asynchronous) leaves the buzzer silent and idle with
// all counts and durations at zero and both channel registers empty.
module beep_pattern_sequencer import bps_pkg::*; #(
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bps_in_if.sink    in_i,
  bps_out_if.source out_o
);

  logic      in_vld_q;
  bps_item_t in_item_q;
  logic      core_ready;

  assign in_i.ready = !in_vld_q || core_ready;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (core_ready) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register word
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= '{kind:        in_i.kind,
                     repetitions: in_i.repetitions,
                     on_time_ms:  in_i.on_time_ms,
                     off_time_ms: in_i.off_time_ms};
    end
  end

  // pattern state and result register
  bps_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_vld_q),
    .item_i       (in_item_q),
    .item_ready_o (core_ready),
    .out_o        (out_o)
  );

endmodule

>>> hw/rtl/bps_checker.sv
`include "beep_pattern_sequencer_assert.svh"

module bps_assert_checker import bps_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               buzzer_level_i,
  input logic [PHASE_W-1:0] phase_i,
  input logic [BEEPS_W-1:0] beeps_left_i,
  input logic               sequence_done_i
);

  logic ph_on;
  logic ph_idle;
  logic ph_wait;
  logic none_left;
  logic done_word;

  // decoded view of the result word
  assign ph_on     = (phase_i == PH_ON);
  assign ph_idle   = (phase_i == PH_IDLE);
  assign ph_wait   = (phase_i == PH_WAIT);
  assign none_left = (beeps_left_i == '0);
  assign done_word = out_valid_i && sequence_done_i;

  // a stalled result word stays offered
  `BPS_ASSERT_IMP(a_out_hold, out_valid_i && !out_ready_i, ##1 out_valid_i, "result dropped")

  // the buzzer sounds exactly in the on phase
  `BPS_ASSERT_IMP(a_level_phase, out_valid_i, buzzer_level_i == ph_on, "level vs phase")

  // a finished sequence leaves the buzzer idle with nothing left
  `BPS_ASSERT_IMP(a_done_idle, done_word, ph_idle && none_left, "sequence end not idle")

  // waiting between beeps means another beep is due
  `BPS_ASSERT_IMP(a_wait_left, out_valid_i && ph_wait, !none_left, "wait with none left")

endmodule

bind beep_pattern_sequencer bps_assert_checker u_bps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .buzzer_level_i  (out_o.buzzer_level),
  .phase_i         (out_o.phase),
  .beeps_left_i    (out_o.beeps_left),
  .sequence_done_i (out_o.sequence_done)
);

>>> tb/bps_checker.sv
// watches both channels of the beep sequencer, predicts each result word and
// compares it with what the block returns
module bps_checker import bps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bps_in_if           in_mon_i,
  bps_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned ELAPSED_W   = TIME_BITS_DEF + 1;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic               buzzer_level;
    logic [PHASE_W-1:0] phase;
    logic [BEEPS_W-1:0] beeps_left;
    logic               sequence_done;
  } buzzer_status_t;

  // predicted buzzer state
  logic [PHASE_W-1:0]        phase_q;
  logic [COUNT_BITS_DEF-1:0] beeps_q;
  logic [ELAPSED_W-1:0]      elapsed_q;
  logic [TIME_BITS_DEF-1:0]  on_len_q;
  logic [TIME_BITS_DEF-1:0]  off_len_q;
  logic                      seq_active_q;
  logic                      drive_q;

  // status words still owed by the block, oldest first
  buzzer_status_t owed_status_q[$];

  // force on: sounding with no timeout, any sequence dropped
  function automatic void hold_on();
    beeps_q      = '0;
    drive_q      = 1'b1;
    seq_active_q = 1'b0;
    phase_q      = PH_ON;
  endfunction

  // force off: silent and idle, any sequence dropped
  function automatic void hold_quiet();
    beeps_q      = '0;
    drive_q      = 1'b0;
    seq_active_q = 1'b0;
    phase_q      = PH_IDLE;
  endfunction

  // advance the predicted state by one word and give the status after it
  function automatic buzzer_status_t buzzer_after(input bps_item_t w);
    buzzer_status_t s;
    logic           done;
    done = 1'b0;
    case (w.kind)
      KIND_TICK: begin
        // elapsed count saturates rather than wrapping
        if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
        if (phase_q == PH_ON) begin
          if (seq_active_q && elapsed_q > ELAPSED_W'(on_len_q)) begin
            drive_q   = 1'b0;
            elapsed_q = '0;
            if (beeps_q != '0) beeps_q = beeps_q - 1'b1;
            if (beeps_q != '0) begin
              phase_q = PH_WAIT;
            end else begin
              phase_q      = PH_IDLE;
              seq_active_q = 1'b0;
              done         = 1'b1;
            end
          end
        end else if (phase_q == PH_WAIT) begin
          if (elapsed_q >= ELAPSED_W'(off_len_q)) begin
            drive_q   = 1'b1;
            elapsed_q = '0;
            phase_q   = PH_ON;
          end
        end
      end
      KIND_START: begin
        // zero repetitions still give one beep
        beeps_q      = (COUNT_BITS_DEF'(w.repetitions) == '0) ? COUNT_BITS_DEF'(1)
                                                              : COUNT_BITS_DEF'(w.repetitions);
        on_len_q     = TIME_BITS_DEF'(w.on_time_ms);
        off_len_q    = TIME_BITS_DEF'(w.off_time_ms);
        elapsed_q    = '0;
        drive_q      = 1'b1;
        phase_q      = PH_ON;
        seq_active_q = 1'b1;
      end
      KIND_FORCE_ON:  hold_on();
      KIND_FORCE_OFF: hold_quiet();
      KIND_TOGGLE: begin
        if (drive_q) hold_quiet();
        else hold_on();
      end
      default: ;
    endcase
    s.buzzer_level  = drive_q;
    s.phase         = phase_q;
    s.beeps_left    = (beeps_q > BEEPS_MAX) ? BEEPS_MAX : BEEPS_W'(beeps_q);
    s.sequence_done = done;
    return s;
  endfunction

  // predict on every accepted input word, compare on every accepted result word
  always @(posedge clk_i or negedge rst_ni) begin
    bps_item_t      w;
    buzzer_status_t seen;
    buzzer_status_t want;
    if (!rst_ni) begin
      phase_q      = PH_IDLE;
      beeps_q      = '0;
      elapsed_q    = '0;
      on_len_q     = '0;
      off_len_q    = '0;
      seq_active_q = 1'b0;
      drive_q      = 1'b0;
      owed_status_q.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        w.kind        = in_mon_i.kind;
        w.repetitions = in_mon_i.repetitions;
        w.on_time_ms  = in_mon_i.on_time_ms;
        w.off_time_ms = in_mon_i.off_time_ms;
        owed_status_q.push_back(buzzer_after(w));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        seen.buzzer_level  = out_mon_i.buzzer_level;
        seen.phase         = out_mon_i.phase;
        seen.beeps_left    = out_mon_i.beeps_left;
        seen.sequence_done = out_mon_i.sequence_done;
        if (owed_status_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("bps_checker: %0t result word with none owed: lvl %0b ph %0d left %0d done %0b",
                     $realtime, seen.buzzer_level, seen.phase, seen.beeps_left,
                     seen.sequence_done);
        end else begin
          want = owed_status_q.pop_front();
          if (seen.buzzer_level !== want.buzzer_level || seen.phase !== want.phase ||
              seen.beeps_left !== want.beeps_left ||
              seen.sequence_done !== want.sequence_done) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS)
              $display("bps_checker: %0t mismatch exp lvl %0b ph %0d left %0d done %0b, got lvl %0b ph %0d left %0d done %0b",
                       $realtime, want.buzzer_level, want.phase, want.beeps_left,
                       want.sequence_done, seen.buzzer_level, seen.phase,
                       seen.beeps_left, seen.sequence_done);
          end
        end
      end
      pending_o <= owed_status_q.size();
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  import bps_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RANDOM_WORDS = 1450;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_ALTERNATE, RX_LONG_STALL} rx_mode_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_ready = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;

  bps_in_if  in_if ();
  bps_out_if out_if ();

  assign out_if.ready = rx_ready;

  beep_pattern_sequencer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bps_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // receiver back-pressure: a mode picked at random every so often
  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;

  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 120);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_FREE:      rx_ready <= 1'b1;
      RX_COIN:      rx_ready <= $urandom_range(0, 1);
      RX_ALTERNATE: rx_ready <= ~rx_ready;
      RX_LONG_STALL: begin
        if (rx_hold_left == 0) begin
          rx_ready     <= ~rx_ready;
          rx_hold_left  = rx_ready ? $urandom_range(1, 8) : $urandom_range(1, 4);
        end else begin
          rx_hold_left--;
        end
      end
      default: rx_ready <= 1'b1;
    endcase
  end

  // drive one word, idling between bursts, and wait until it is taken
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [REPS_W-1:0] reps,
                           input logic [TIME_W-1:0] on_ms, input logic [TIME_W-1:0] off_ms);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.repetitions <= reps;
    in_if.on_time_ms  <= on_ms;
    in_if.off_time_ms <= off_ms;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    words_sent++;
  endtask

  // tick with random don't-care fields
  task automatic send_tick();
    send_word(KIND_TICK, REPS_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
  endtask

  // any kind, unused ones included, with random fields
  task automatic send_noise();
    send_word(KIND_W'($urandom_range(0, (1 << KIND_W) - 1)), REPS_W'($urandom),
              TIME_W'($urandom), TIME_W'($urandom));
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    return ($urandom_range(0, 99) < 75) ? TIME_W'($urandom_range(0, 4)) : TIME_W'($urandom);
  endfunction

  // run timeout
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned            word_target;
    int unsigned            pick;
    logic [REPS_W-1:0]      reps;
    logic [TIME_W-1:0]      on_ms;
    logic [TIME_W-1:0]      off_ms;
    int unsigned            full_ticks;
    int unsigned            n_ticks;

    in_if.valid       = 1'b0;
    in_if.kind        = KIND_TICK;
    in_if.repetitions = '0;
    in_if.on_time_ms  = '0;
    in_if.off_time_ms = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick with every field at its top, then the unused kinds
    send_word(KIND_TICK, '1, '1, '1);
    for (int k = int'(KIND_TOGGLE) + 1; k < (1 << KIND_W); k++)
      send_word(KIND_W'(k), '1, '1, '1);

    // zero repetitions and zero times: one beep ending on the first tick
    send_word(KIND_START, '0, '0, '0);
    send_tick();

    // two beeps, on time of one, zero pause between them
    send_word(KIND_START, REPS_W'(2), TIME_W'(1), '0);
    repeat (5) send_tick();

    // longest pattern cancelled by a restart, then by force on
    send_word(KIND_START, '1, '1, '1);
    send_tick();
    send_word(KIND_START, REPS_W'(3), '0, TIME_W'(1));
    send_tick();
    send_tick();
    send_word(KIND_FORCE_ON, '0, '0, '0);
    send_tick();

    // toggle both ways, force off, toggle from idle
    send_word(KIND_TOGGLE, '0, '0, '0);
    send_word(KIND_TOGGLE, '1, '1, '1);
    send_word(KIND_FORCE_OFF, '0, '0, '0);
    send_word(KIND_TOGGLE, '0, '0, '0);

    // random part: mostly full or cut-short beep sequences, some noise
    word_target = words_sent + RANDOM_WORDS;
    while (words_sent < word_target) begin
      if ($urandom_range(0, 99) < 20) begin
        send_noise();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) reps = '0;
        else if (pick < 65) reps = REPS_W'($urandom_range(1, 4));
        else if (pick < 85) reps = REPS_W'($urandom_range(5, 16));
        else reps = REPS_W'($urandom);
        on_ms  = pick_time();
        off_ms = pick_time();
        send_word(KIND_START, reps, on_ms, off_ms);
        // enough ticks to run the whole pattern out
        full_ticks = ((reps == '0) ? 1 : int'(reps)) * (int'(on_ms) + int'(off_ms) + 2) + 2;
        if (full_ticks <= 150 && $urandom_range(0, 3) != 0)
          n_ticks = full_ticks + $urandom_range(0, 3);
        else
          n_ticks = $urandom_range(1, (full_ticks < 40) ? full_ticks : 40);
        for (int unsigned i = 0; i < n_ticks; i++) begin
          if ($urandom_range(0, 49) == 0) send_noise();
          else send_tick();
        end
      end
    end
    in_if.valid <= 1'b0;

    // let the last words come out
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bps_pkg.sv
hw/rtl/bps_if.sv
hw/rtl/bps_core.sv
hw/rtl/beep_pattern_sequencer.sv
hw/rtl/bps_checker.sv
tb/bps_checker.sv
tb/tb.sv
